// ===== rtl/swhfd_pkg.sv =====
// swhfd_pkg: shared types and constants for the single-wire humidity frame decoder
// used by swhfd_frame, swhfd_convert and single_wire_humidity_frame_decoder_core
// no dependencies
`default_nettype none

package swhfd_pkg;

   localparam int FRAME_BYTES = 5;
   localparam int FRAME_BITS  = 40;
   localparam int CSR_INDEX_W = 2;

   // fahrenheit tenths: (c * 9 + 1600) / 5, divide done by reciprocal multiply
   localparam logic [18:0] FAH_OFFSET = 19'd1600;
   localparam logic [19:0] DIV5_RECIP = 20'd838861;
   localparam int          DIV5_SHIFT = 22;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam logic END_IDLE  = 1'b0;
   localparam logic END_ABORT = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ONE_BIT_MIN = 2'd0,
      CSR_ABORT_MIN   = 2'd1,
      CSR_IDLE_TIMEOUT = 2'd2,
      CSR_LEAD_PULSES = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] one_bit_min_ticks;
      logic [7:0] abort_min_ticks;
      logic [7:0] idle_timeout_ticks;
      logic [2:0] lead_pulses;
   } cfg_type;

   typedef struct packed {
      logic [FRAME_BYTES-1:0][7:0] bytes;
      logic                        end_reason;
      logic [5:0]                  bits_received;
   } frame_type;

endpackage

`default_nettype wire

// ===== rtl/swhfd_frame.sv =====
// swhfd_frame: pulse measurement, bit assembly and frame capture register
// depends on swhfd_pkg
`default_nettype none

module swhfd_frame (
   input  logic                clock,
   input  logic                reset,
   input  swhfd_pkg::cfg_type  cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic                req_line_level,
   output logic                frame_valid,
   input  logic                frame_ready,
   output swhfd_pkg::frame_type frame_out
);
   import swhfd_pkg::*;

   logic                        active_ff, active_in;
   logic [7:0]                  high_ff, high_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [3:0]                  bib_ff, bib_in;
   logic [5:0]                  pulse_ff, pulse_in;
   logic [FRAME_BYTES-1:0][7:0] bytes_ff, bytes_in;
   logic                        out_valid_ff, out_valid_in;
   frame_type                   out_ff, out_in;

   logic       accept;
   logic       emit;
   logic       reason;
   logic [7:0] high_inc;
   logic [5:0] pulse_nx;
   logic [5:0] bits_now;
   logic [5:0] bits_nx;
   logic       bit_val;
   logic [7:0] shift_nx;
   logic [3:0] bib_nx;
   logic [2:0] byte_sel;
   logic [2:0] byte_idx;

   function automatic logic [5:0] data_bits(input logic [5:0] pc, input logic [2:0] lead);
      logic [5:0] n;
      n = pc - {3'b000, lead};
      if (pc <= {3'b000, lead}) begin
         return 6'd0;
      end
      if (n > 6'(FRAME_BITS)) begin
         return 6'(FRAME_BITS);
      end
      return n;
   endfunction

   assign req_stall   = out_valid_ff & ~frame_ready;
   assign accept      = req_valid & ~req_stall;
   assign frame_valid = out_valid_ff;
   assign frame_out   = out_ff;

   assign high_inc = (high_ff != 8'hFF) ? high_ff + 8'd1 : high_ff;
   assign pulse_nx = pulse_ff + 6'd1;
   assign bits_now = data_bits(pulse_ff, cfg.lead_pulses);
   assign bits_nx  = data_bits(pulse_nx, cfg.lead_pulses);
   assign bit_val  = (high_ff >= cfg.one_bit_min_ticks);
   assign shift_nx = {shift_ff[6:0], bit_val};
   assign bib_nx   = bib_ff + 4'd1;
   assign byte_sel = bits_nx[5:3];
   assign byte_idx = byte_sel - 3'd1;

   always_comb begin
      active_in = active_ff;
      high_in   = high_ff;
      shift_in  = shift_ff;
      bib_in    = bib_ff;
      pulse_in  = pulse_ff;
      bytes_in  = bytes_ff;
      emit      = 1'b0;
      reason    = END_IDLE;
      if (accept) begin
         if (req_cmd == CMD_START) begin
            active_in = 1'b1;
            high_in   = 8'd0;
            shift_in  = 8'd0;
            bib_in    = 4'd0;
            pulse_in  = 6'd0;
            bytes_in  = '0;
         end else if (active_ff) begin
            if (req_line_level) begin
               high_in = high_inc;
               if (high_inc >= cfg.idle_timeout_ticks) begin
                  emit      = 1'b1;
                  reason    = END_IDLE;
                  active_in = 1'b0;
               end
            end else if (high_ff != 8'd0) begin
               if (high_ff >= cfg.abort_min_ticks) begin
                  emit      = 1'b1;
                  reason    = END_ABORT;
                  active_in = 1'b0;
               end else begin
                  high_in = 8'd0;
                  if (bits_now < 6'(FRAME_BITS)) begin
                     pulse_in = pulse_nx;
                     if (pulse_nx > {3'b000, cfg.lead_pulses}) begin
                        shift_in = shift_nx;
                        bib_in   = bib_nx;
                        if (bib_nx >= 4'd8) begin
                           if (byte_sel != 3'd0 && byte_sel <= 3'(FRAME_BYTES)) begin
                              bytes_in[byte_idx] = shift_nx;
                           end
                           shift_in = 8'd0;
                           bib_in   = 4'd0;
                        end
                     end
                  end
               end
            end
         end
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (frame_ready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in         = 1'b1;
         out_in.bytes         = bytes_ff;
         out_in.end_reason    = reason;
         out_in.bits_received = bits_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         high_ff      <= 8'd0;
         shift_ff     <= 8'd0;
         bib_ff       <= 4'd0;
         pulse_ff     <= 6'd0;
         bytes_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         high_ff      <= high_in;
         shift_ff     <= shift_in;
         bib_ff       <= bib_in;
         pulse_ff     <= pulse_in;
         bytes_ff     <= bytes_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

// ===== rtl/swhfd_convert.sv =====
// swhfd_convert: frame bytes to humidity, celsius, fahrenheit and checksum flag
// two register stages with the result register; depends on swhfd_pkg
`default_nettype none

module swhfd_convert (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frame_valid,
   output logic                 frame_ready,
   input  swhfd_pkg::frame_type frame_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [15:0]          rsp_humidity_tenths,
   output logic signed [15:0]   rsp_celsius_tenths,
   output logic signed [16:0]   rsp_fahrenheit_tenths,
   output logic                 rsp_checksum_ok,
   output logic                 rsp_end_reason,
   output logic [5:0]           rsp_bits_received
);
   import swhfd_pkg::*;

   // stage b: decoded values and fahrenheit numerator magnitude
   logic        b_valid_ff;
   logic [15:0] b_hum_ff, b_hum_in;
   logic [15:0] b_cel_ff, b_cel_in;
   logic        b_ok_ff, b_ok_in;
   logic        b_reason_ff;
   logic [5:0]  b_bits_ff;
   logic [18:0] b_ax_ff, b_ax_in;
   logic        b_xneg_ff, b_xneg_in;

   // stage c: result register
   logic        c_valid_ff;
   logic [15:0] c_hum_ff;
   logic [15:0] c_cel_ff;
   logic [16:0] c_fah_ff, c_fah_in;
   logic        c_ok_ff;
   logic        c_reason_ff;
   logic [5:0]  c_bits_ff;

   logic        c_ready;
   logic        b_ready;
   logic [7:0]  b0, b1, b2, b3, b4;
   logic [14:0] mag;
   logic [18:0] mag9;
   logic [7:0]  sum;
   logic [38:0] prod;
   logic [16:0] quot;

   assign c_ready     = ~c_valid_ff | ~rsp_stall;
   assign b_ready     = ~b_valid_ff | c_ready;
   assign frame_ready = b_ready;

   assign b0 = frame_in.bytes[0];
   assign b1 = frame_in.bytes[1];
   assign b2 = frame_in.bytes[2];
   assign b3 = frame_in.bytes[3];
   assign b4 = frame_in.bytes[4];

   assign mag  = {b2[6:0], b3};
   assign mag9 = {1'b0, mag, 3'b000} + {4'b0000, mag};
   assign sum  = b0 + b1 + b2 + b3;

   always_comb begin
      b_hum_in = {b0, b1};
      b_cel_in = b2[7] ? 16'd0 - {1'b0, mag} : {1'b0, mag};
      b_ok_in  = (b4 == sum) && (sum != 8'd0);
      if (!b2[7]) begin
         b_ax_in   = mag9 + FAH_OFFSET;
         b_xneg_in = 1'b0;
      end else if (mag9 >= FAH_OFFSET) begin
         b_ax_in   = mag9 - FAH_OFFSET;
         b_xneg_in = 1'b1;
      end else begin
         b_ax_in   = FAH_OFFSET - mag9;
         b_xneg_in = 1'b0;
      end
   end

   assign prod     = 39'(b_ax_ff) * 39'(DIV5_RECIP);
   assign quot     = prod[DIV5_SHIFT +: 17];
   assign c_fah_in = b_xneg_ff ? 17'd0 - quot : quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (b_ready) begin
            b_valid_ff <= frame_valid;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && frame_valid) begin
         b_hum_ff    <= b_hum_in;
         b_cel_ff    <= b_cel_in;
         b_ok_ff     <= b_ok_in;
         b_reason_ff <= frame_in.end_reason;
         b_bits_ff   <= frame_in.bits_received;
         b_ax_ff     <= b_ax_in;
         b_xneg_ff   <= b_xneg_in;
      end
      if (c_ready && b_valid_ff) begin
         c_hum_ff    <= b_hum_ff;
         c_cel_ff    <= b_cel_ff;
         c_fah_ff    <= c_fah_in;
         c_ok_ff     <= b_ok_ff;
         c_reason_ff <= b_reason_ff;
         c_bits_ff   <= b_bits_ff;
      end
   end

   assign rsp_valid             = c_valid_ff;
   assign rsp_humidity_tenths   = c_hum_ff;
   assign rsp_celsius_tenths    = c_cel_ff;
   assign rsp_fahrenheit_tenths = c_fah_ff;
   assign rsp_checksum_ok       = c_ok_ff;
   assign rsp_end_reason        = c_reason_ff;
   assign rsp_bits_received     = c_bits_ff;

endmodule

`default_nettype wire

// ===== rtl/single_wire_humidity_frame_decoder_core.sv =====
// single_wire_humidity_frame_decoder_core: top level, configuration registers
// depends on swhfd_pkg, swhfd_frame and swhfd_convert
//
// usage:
//   req channel: one item per microsecond tick; req_cmd selects a sample tick
//   (req_line_level is the sampled line) or a start that clears and arms a frame
//   rsp channel: one item per finished frame (idle timeout or overlong pulse abort)
//   with humidity, celsius and fahrenheit tenths, checksum flag, end reason and
//   the number of data bits received
//   csr port: csr_write with csr_index and csr_data sets one of the four thresholds,
//   effective from the next item
// timing:
//   one req item per cycle sustained while req_stall is low; the frame state updates in the cycle of accept
//   a result passes the frame output register, stage b and the rsp register after the item that ends the frame
// reset:
//   synchronous, active high; thresholds return to 30, 85, 200 and 2 and the
//   decoder waits idle for a start item
// stall:
//   results queue in three register stages; req_stall rises only when all three
//   hold a result and rsp_stall is high
`default_nettype none

module single_wire_humidity_frame_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic                              req_line_level,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_humidity_tenths,
   output logic signed [15:0]                rsp_celsius_tenths,
   output logic signed [16:0]                rsp_fahrenheit_tenths,
   output logic                              rsp_checksum_ok,
   output logic                              rsp_end_reason,
   output logic [5:0]                        rsp_bits_received,
   input  logic                              csr_write,
   input  logic [swhfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                        csr_data
);
   import swhfd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   frame_type frame;
   logic      frame_valid;
   logic      frame_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_ONE_BIT_MIN:  cfg_in.one_bit_min_ticks  = csr_data;
            CSR_ABORT_MIN:    cfg_in.abort_min_ticks    = csr_data;
            CSR_IDLE_TIMEOUT: cfg_in.idle_timeout_ticks = csr_data;
            CSR_LEAD_PULSES:  cfg_in.lead_pulses        = csr_data[2:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_bit_min_ticks  <= 8'd30;
         cfg_ff.abort_min_ticks    <= 8'd85;
         cfg_ff.idle_timeout_ticks <= 8'd200;
         cfg_ff.lead_pulses        <= 3'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swhfd_frame u_frame (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_line_level (req_line_level),
      .frame_valid    (frame_valid),
      .frame_ready    (frame_ready),
      .frame_out      (frame)
   );

   swhfd_convert u_convert (
      .clock                 (clock),
      .reset                 (reset),
      .frame_valid           (frame_valid),
      .frame_ready           (frame_ready),
      .frame_in              (frame),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_humidity_tenths   (rsp_humidity_tenths),
      .rsp_celsius_tenths    (rsp_celsius_tenths),
      .rsp_fahrenheit_tenths (rsp_fahrenheit_tenths),
      .rsp_checksum_ok       (rsp_checksum_ok),
      .rsp_end_reason        (rsp_end_reason),
      .rsp_bits_received     (rsp_bits_received)
   );

endmodule

`default_nettype wire
